/* design/pws_pkg.sv */
// ----------------------------------------------------------------------------
// pws_pkg
// shared widths, register indexes and types for the world-to-screen projector
// ----------------------------------------------------------------------------
package pws_pkg;

	localparam int CoefW = 32;          // Q8.24 matrix entry
	localparam int PointW = 32;         // Q16.16 coordinate
	localparam int ClipW = 42;          // clip value in Q.16
	localparam int DimW = 14;           // viewport dimension
	localparam int ScaledW = ClipW + DimW + 1;
	localparam int NumW = 63;           // dividend magnitude after the scale by 128
	localparam int DivW = 40;           // divisor width, w is below 2^40 when visible
	localparam int OutW = 32;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 64;
	localparam int DivStages = NumW;

	localparam logic signed [ClipW-1:0] WMin = ClipW'(656);
	localparam logic [DimW-1:0] WidthReset = DimW'(1920);
	localparam logic [DimW-1:0] HeightReset = DimW'(1080);

	typedef enum logic [CfgIdxW-1:0] {
		REG_ROW0_A,
		REG_ROW0_B,
		REG_ROW1_A,
		REG_ROW1_B,
		REG_ROW3_A,
		REG_ROW3_B,
		REG_WIDTH,
		REG_HEIGHT
	} reg_idx_t;

	// three rows of four entries
	typedef logic [2:0][3:0][CoefW-1:0] matrix_t;

	typedef struct packed {
		logic valid;
		logic visible;
	} tag_t;

endpackage

/* design/pws_clip.sv */
// ----------------------------------------------------------------------------
// pws_clip
// two stage clip transform: nine registered products, then the row sums
// ----------------------------------------------------------------------------
module pws_clip import pws_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [PointW-1:0] px,
	input  logic signed [PointW-1:0] py,
	input  logic signed [PointW-1:0] pz,
	input  matrix_t                  coefs,
	output logic                     out_valid,
	output logic signed [ClipW-1:0]  cx,
	output logic signed [ClipW-1:0]  cy,
	output logic signed [ClipW-1:0]  cw
);

	logic signed [PointW-1:0] pt [3];
	logic signed [2*CoefW-1:0] prod_s1 [3][3];
	logic signed [ClipW-1:0] off_s1 [3];
	logic signed [ClipW-1:0] sum_s2 [3];
	logic valid_s1, valid_s2;

	assign pt[0] = px;
	assign pt[1] = py;
	assign pt[2] = pz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= $signed(coefs[r][c]) * pt[c];
			end
			off_s1[r] <= ClipW'($signed(coefs[r][3]) >>> 8);
		end
	end

	// arithmetic shifts give the floor rounding to Q.16
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			sum_s2[r] <= ClipW'(prod_s1[r][0] >>> 24) + ClipW'(prod_s1[r][1] >>> 24)
				+ ClipW'(prod_s1[r][2] >>> 24) + off_s1[r];
		end
	end

	assign out_valid = valid_s2;
	assign cx = sum_s2[0];
	assign cy = sum_s2[1];
	assign cw = sum_s2[2];

endmodule

/* design/pws_div.sv */
// ----------------------------------------------------------------------------
// pws_div
// pipelined restoring divider, one quotient bit per stage, two lanes share w
// ----------------------------------------------------------------------------
module pws_div import pws_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  tag_t                in_tag,
	input  logic [NumW-1:0]     num_x,
	input  logic [NumW-1:0]     num_y,
	input  logic                neg_x,
	input  logic                neg_y,
	input  logic [DivW-1:0]     den,
	output tag_t                out_tag,
	output logic [NumW-1:0]     quo_x,
	output logic [NumW-1:0]     quo_y,
	output logic                rnz_x,
	output logic                rnz_y,
	output logic                out_neg_x,
	output logic                out_neg_y
);

	// nq shifts the dividend out at the top and the quotient in at the bottom
	logic [NumW-1:0] nq [DivStages+1][2];
	logic [DivW-1:0] rem [DivStages+1][2];
	logic neg [DivStages+1][2];
	logic [DivW-1:0] dv [DivStages+1];
	tag_t tag [DivStages+1];

	assign nq[0][0] = num_x;
	assign nq[0][1] = num_y;
	assign rem[0][0] = '0;
	assign rem[0][1] = '0;
	assign neg[0][0] = neg_x;
	assign neg[0][1] = neg_y;
	assign dv[0] = den;
	assign tag[0] = in_tag;

	for (genvar k = 0; k < DivStages; k++) begin : g_stage
		logic [DivW:0] trial [2];
		logic [DivW:0] diff [2];
		logic fits [2];

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {rem[k][l], nq[k][l][NumW-1]};
				diff[l] = trial[l] - {1'b0, dv[k]};
				fits[l] = trial[l] >= {1'b0, dv[k]};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag[k+1] <= '0;
			end else begin
				tag[k+1] <= tag[k];
			end
		end

		always_ff @(posedge clk) begin
			dv[k+1] <= dv[k];
			for (int l = 0; l < 2; l++) begin
				rem[k+1][l] <= fits[l] ? diff[l][DivW-1:0] : trial[l][DivW-1:0];
				nq[k+1][l] <= {nq[k][l][NumW-2:0], fits[l]};
				neg[k+1][l] <= neg[k][l];
			end
		end
	end

	assign out_tag = tag[DivStages];
	assign quo_x = nq[DivStages][0];
	assign quo_y = nq[DivStages][1];
	assign rnz_x = |rem[DivStages][0];
	assign rnz_y = |rem[DivStages][1];
	assign out_neg_x = neg[DivStages][0];
	assign out_neg_y = neg[DivStages][1];

endmodule

/* design/perspective_world_to_screen.sv */
// ----------------------------------------------------------------------------
// perspective_world_to_screen
// world point to viewport pixel through rows 0, 1 and 3 of a view-projection
// matrix, perspective divide and viewport mapping
// ----------------------------------------------------------------------------
// done follows start through the clip, scale, divider and floor stages
// throughput: one item per cycle, busy is always low; the 63-stage divider
// pipeline sets the latency
// done cannot be held off: each result shows for exactly one cycle
// reset: coefficients clear to zero, width 1920, height 1080, pipeline empties
module perspective_world_to_screen import pws_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [PointW-1:0] point_x,
	input  logic signed [PointW-1:0] point_y,
	input  logic signed [PointW-1:0] point_z,
	input  logic                     wr_en,
	input  logic [CfgIdxW-1:0]       wr_index,
	input  logic [CfgDataW-1:0]      wr_data,
	output logic                     done,
	output logic                     visible,
	output logic signed [OutW-1:0]   screen_x,
	output logic signed [OutW-1:0]   screen_y
);

	matrix_t coefs_q;
	logic [DimW-1:0] width_q, height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q <= '0;
			width_q <= WidthReset;
			height_q <= HeightReset;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ROW0_A, REG_ROW0_B, REG_ROW1_A,
				REG_ROW1_B, REG_ROW3_A, REG_ROW3_B: begin
					coefs_q[wr_index[2:1]][{wr_index[0], 1'b0}] <= wr_data[CoefW-1:0];
					coefs_q[wr_index[2:1]][{wr_index[0], 1'b1}] <= wr_data[2*CoefW-1:CoefW];
				end
				REG_WIDTH:  width_q <= wr_data[DimW-1:0];
				REG_HEIGHT: height_q <= wr_data[DimW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	logic clip_valid;
	logic signed [ClipW-1:0] cx, cy, cw;

	pws_clip u_clip (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.px       (point_x),
		.py       (point_y),
		.pz       (point_z),
		.coefs    (coefs_q),
		.out_valid(clip_valid),
		.cx       (cx),
		.cy       (cy),
		.cw       (cw)
	);

	// scale by the viewport dimension
	tag_t tag_s3, tag_s4;
	logic signed [ScaledW-1:0] numx_s3, numy_s3;
	logic [DivW-1:0] w_s3, w_s4;
	logic [NumW-1:0] magx_s4, magy_s4;
	logic negx_s4, negy_s4;
	logic [ScaledW-1:0] absx, absy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s3 <= '{valid: clip_valid, visible: cw >= WMin};
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		numx_s3 <= ScaledW'(cx * $signed({1'b0, width_q}));
		numy_s3 <= ScaledW'(cy * $signed({1'b0, height_q}));
		w_s3 <= cw[DivW-1:0];
	end

	assign absx = numx_s3[ScaledW-1] ? -numx_s3 : numx_s3;
	assign absy = numy_s3[ScaledW-1] ? -numy_s3 : numy_s3;

	// the factor 128 is a shift into the dividend
	always_ff @(posedge clk) begin
		magx_s4 <= {absx[NumW-8:0], 7'b0};
		magy_s4 <= {absy[NumW-8:0], 7'b0};
		negx_s4 <= numx_s3[ScaledW-1];
		negy_s4 <= numy_s3[ScaledW-1];
		w_s4 <= w_s3;
	end

	tag_t div_tag;
	logic [NumW-1:0] qx, qy;
	logic rnzx, rnzy, dnegx, dnegy;

	pws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (tag_s4),
		.num_x    (magx_s4),
		.num_y    (magy_s4),
		.neg_x    (negx_s4),
		.neg_y    (negy_s4),
		.den      (w_s4),
		.out_tag  (div_tag),
		.quo_x    (qx),
		.quo_y    (qy),
		.rnz_x    (rnzx),
		.rnz_y    (rnzy),
		.out_neg_x(dnegx),
		.out_neg_y(dnegy)
	);

	// floor quotient from magnitude quotient and remainder
	tag_t tag_s5;
	logic signed [63:0] tx_s5, ty_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s5 <= '0;
		end else begin
			tag_s5 <= div_tag;
		end
	end

	always_ff @(posedge clk) begin
		tx_s5 <= dnegx ? -($signed({1'b0, qx}) + 64'(rnzx)) : $signed({1'b0, qx});
		ty_s5 <= dnegy ? -($signed({1'b0, qy}) + 64'(rnzy)) : $signed({1'b0, qy});
	end

	// viewport offset, half pixel and saturation
	logic signed [63:0] sx_full, sy_full;
	logic signed [OutW-1:0] sx_sat, sy_sat;

	assign sx_full = $signed(64'({width_q[DimW-1:1], 8'b0})) + tx_s5 + 64'sd128;
	assign sy_full = $signed(64'({height_q[DimW-1:1], 8'b0})) - (ty_s5 + 64'sd128);

	always_comb begin
		sx_sat = sx_full[OutW-1:0];
		sy_sat = sy_full[OutW-1:0];
		if (sx_full > 64'sh7FFF_FFFF) sx_sat = {1'b0, {(OutW-1){1'b1}}};
		else if (sx_full < -64'sh8000_0000) sx_sat = {1'b1, {(OutW-1){1'b0}}};
		if (sy_full > 64'sh7FFF_FFFF) sy_sat = {1'b0, {(OutW-1){1'b1}}};
		else if (sy_full < -64'sh8000_0000) sy_sat = {1'b1, {(OutW-1){1'b0}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_s5.valid;
		end
	end

	always_ff @(posedge clk) begin
		visible <= tag_s5.visible;
		screen_x <= tag_s5.visible ? sx_sat : '0;
		screen_y <= tag_s5.visible ? sy_sat : '0;
	end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for perspective_world_to_screen: loads view-projection
// matrices and viewport sizes, streams world points and checks every pixel
// against a listed value or an in-bench fixed-point projection
// ----------------------------------------------------------------------------
module tb;
	import pws_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchLimit = 3000;
	localparam int DrainCycles = 80;
	localparam int PhaseItems = 160;
	localparam int NumPhases = 8;

	typedef struct {
		logic               vis;
		logic signed [31:0] sx;
		logic signed [31:0] sy;
	} pixel_t;

	typedef struct {
		logic [31:0] x, y, z;
		bit          typed;
		pixel_t      px;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [PointW-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic wr_en = 1'b0;
	logic [CfgIdxW-1:0] wr_index = '0;
	logic [CfgDataW-1:0] wr_data = '0;
	logic done, visible;
	logic signed [OutW-1:0] screen_x, screen_y;

	perspective_world_to_screen u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .visible(visible), .screen_x(screen_x), .screen_y(screen_y)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the matrix rows 0, 1, 3 and the viewport
	logic signed [31:0] mat [3][4];
	longint view_w, view_h;

	pixel_t pending_q[$];   // what the driver attaches to each raised item
	pixel_t pixel_q[$];     // projected pixels still to come out
	int errors = 0;
	int n_items = 0, n_pixels = 0, n_visible = 0, n_sat = 0;
	int idle_pct = 0;

	function automatic longint floor_div(longint num, longint den);
		longint q;
		q = num / den;
		if ((num % den) != 0 && num < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint clip_value(int r, longint x, longint y, longint z);
		longint acc;
		acc = (longint'(mat[r][0]) * x) >>> 24;
		acc += (longint'(mat[r][1]) * y) >>> 24;
		acc += (longint'(mat[r][2]) * z) >>> 24;
		acc += longint'(mat[r][3]) >>> 8;
		return acc;
	endfunction

	function automatic pixel_t project_point(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z);
		pixel_t p;
		longint cx, cy, cw, tx, ty;
		cx = clip_value(0, x, y, z);
		cy = clip_value(1, x, y, z);
		cw = clip_value(2, x, y, z);
		p = '{1'b0, 32'sd0, 32'sd0};
		if (cw >= 656) begin
			tx = floor_div(cx * view_w * 128, cw);
			ty = floor_div(cy * view_h * 128, cw);
			p.vis = 1'b1;
			p.sx = 32'(clamp32((view_w >> 1) * 256 + tx + 128));
			p.sy = 32'(clamp32((view_h >> 1) * 256 - (ty + 128)));
		end
		return p;
	endfunction

	task automatic report(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0d expected %0d (pixel %0d)", what, got, want, n_pixels);
	endtask

	// accept side and checking
	always @(posedge clk) begin
		pixel_t e;
		if (start && !busy) begin
			pixel_q.push_back(pending_q.pop_front());
			n_items++;
		end
		if (done) begin
			n_pixels++;
			if (pixel_q.size() == 0) begin
				report("unexpected pixel", visible, -1);
			end else begin
				e = pixel_q.pop_front();
				if (visible !== e.vis) report("visible", visible, e.vis);
				if (screen_x !== e.sx) report("screen_x", screen_x, e.sx);
				if (screen_y !== e.sy) report("screen_y", screen_y, e.sy);
				if (e.vis) n_visible++;
				if (e.vis && (e.sx == 32'h7FFFFFFF || e.sx == 32'h80000000)) n_sat++;
			end
		end
	end

	// watchdog on cycles with nothing accepted and no pixel out
	int quiet = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WatchLimit) begin
			$display("watchdog expired with %0d pixels outstanding", pixel_q.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [63:0] data);
		@(negedge clk);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = data;
		@(negedge clk);
		wr_en = 1'b0;
		case (idx)
			REG_WIDTH: view_w = longint'(data[DimW-1:0]);
			REG_HEIGHT: view_h = longint'(data[DimW-1:0]);
			default: begin
				mat[idx >> 1][(idx & 1) * 2] = data[31:0];
				mat[idx >> 1][(idx & 1) * 2 + 1] = data[63:32];
			end
		endcase
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit typed, pixel_t px);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start = 1'b1;
		point_x = x;
		point_y = y;
		point_z = z;
		pending_q.push_back(typed ? px : project_point(x, y, z));
		do @(posedge clk); while (busy);
	endtask

	task automatic drain;
		@(negedge clk);
		start = 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coef(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'h7FFFFFFF;
			2: return 32'h80000000;
			default: return 32'($signed($urandom_range(1 << 26)) - (1 << 25));
		endcase
	endfunction

	function automatic logic [31:0] rand_coord(bit positive);
		logic [31:0] v;
		case ($urandom_range(9))
			0: v = $urandom();
			1: v = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
			default: v = 32'($signed($urandom_range(1 << 24)) - (1 << 23));
		endcase
		if (positive && $urandom_range(9) != 0)
			v = {1'b0, v[30:0]};
		return v;
	endfunction

	point_row_t dir_rows[$] = '{
		'{32'h0, 32'h0, 32'h00010000, 1'b1, '{1'b1, 32'sd245888, 32'sd138112}},
		'{32'h0, 32'h0, 32'd655, 1'b1, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h0, 32'h0, 32'd656, 1'b0, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h0, 32'h0, 32'h0, 1'b1, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h0, 32'h0, 32'hFFFF0000, 1'b1, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h7FFFFFFF, 32'h7FFFFFFF, 32'd656, 1'b0, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h80000000, 32'h80000000, 32'd656, 1'b0, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h00010000, 32'hFFFF0000, 32'h00010000, 1'b0, '{1'b0, 32'sd0, 32'sd0}},
		'{32'hFFFFFFFF, 32'h00000001, 32'h00020000, 1'b0, '{1'b0, 32'sd0, 32'sd0}},
		'{32'h00C80000, 32'hFF380000, 32'h00008000, 1'b0, '{1'b0, 32'sd0, 32'sd0}}
	};

	initial begin
		pixel_t none;
		int mode;
		none = '{1'b0, 32'sd0, 32'sd0};
		foreach (mat[r, c]) mat[r][c] = '0;
		view_w = 1920;
		view_h = 1080;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// reset state: zero matrix, every point falls behind the eye
		repeat (6) send_point($urandom(), $urandom(), $urandom(), 1'b0, none);
		drain();

		// plain projection, w = z
		write_reg(REG_ROW0_A, {32'h0, 32'h01000000});
		write_reg(REG_ROW1_A, {32'h01000000, 32'h0});
		write_reg(REG_ROW3_B, {32'h0, 32'h01000000});
		foreach (dir_rows[i])
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].typed,
				dir_rows[i].px);
		drain();

		for (int ph = 0; ph < NumPhases; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 60;
				2: idle_pct = 0;
				default: idle_pct = 13;
			endcase
			mode = (ph == 2) ? 1 : (ph == 5) ? 2 : (ph == 6) ? 0 : 3;
			for (int r = 0; r < 2; r++)
				for (int h = 0; h < 2; h++)
					write_reg(reg_idx_t'(r * 2 + h), {rand_coef(mode), rand_coef(mode)});
			// keep w mostly positive so most points project
			write_reg(REG_ROW3_A, {rand_coef(ph == 6 ? 0 : 3), rand_coef(ph == 6 ? 0 : 3)});
			write_reg(REG_ROW3_B, {32'($urandom_range(1 << 24)),
				ph == 5 ? 32'h80000000 : 32'h01000000 + rand_coef(3)});
			case (ph)
				2: begin write_reg(REG_WIDTH, 64'd16383); write_reg(REG_HEIGHT, 64'd1); end
				3: begin write_reg(REG_WIDTH, 64'd1); write_reg(REG_HEIGHT, 64'd16383); end
				4: begin write_reg(REG_WIDTH, 64'd0); write_reg(REG_HEIGHT, 64'd0); end
				default: begin
					write_reg(REG_WIDTH, {$urandom(), $urandom()});
					write_reg(REG_HEIGHT, {$urandom(), $urandom()});
				end
			endcase
			for (int i = 0; i < PhaseItems; i++)
				send_point(rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b1), 1'b0, none);
			drain();
		end

		$display("%0d points sent over %0d matrix settings, %0d pixels checked",
			n_items, NumPhases + 2, n_pixels);
		$display("%0d projected, %0d with x clamped, %0d mismatches",
			n_visible, n_sat, errors);
		if (errors == 0 && pixel_q.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
